// ----- src/lpht_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_pkg: shared types and constants
// Operation codes, slot states, result status codes and sequencer states.
// ----------------------------------------------------------------------------
package lpht_pkg;
	localparam int KEY_W   = 64;
	localparam int KLEN_W  = 4;
	localparam int VOUT_W  = 32;
	localparam int FUNC_W  = 3;
	localparam int STAT_W  = 2;
	localparam int SLOT_W  = 5;
	localparam int CNT_W   = 6;
	localparam int LOAD_W  = 4;
	localparam int THR_W   = 4;
	localparam logic [THR_W-1:0] THR_RESET = 4'd6;
	localparam logic [THR_W-1:0] THR_MIN   = 4'd1;
	localparam logic [THR_W-1:0] THR_MAX   = 4'd10;

	typedef enum logic [FUNC_W-1:0] {
		FN_EXISTS = 3'd0,
		FN_GET    = 3'd1,
		FN_INSERT = 3'd2,
		FN_SET    = 3'd3,
		FN_DELETE = 3'd4
	} func_t;

	typedef enum logic [1:0] {
		SL_EMPTY = 2'd0,
		SL_USED  = 2'd1,
		SL_TOMB  = 2'd2
	} slot_state_t;

	typedef enum logic [STAT_W-1:0] {
		RS_OK     = 2'd0,
		RS_NOTFND = 2'd1,
		RS_EXISTS = 2'd2,
		RS_FULL   = 2'd3
	} rstat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HASH,
		ST_FIND,
		ST_FREE,
		ST_LOAD,
		ST_OUT
	} seq_state_t;
endpackage

// ----- src/lpht_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_req_if / lpht_rsp_if: request and response channels
// Valid/ready channels carrying one request or one result beat.
// ----------------------------------------------------------------------------
interface lpht_req_if;
	logic                        valid;
	logic                        ready;
	logic [2:0]                  func;
	logic [63:0]                 key_bytes;
	logic [3:0]                  key_length;
	logic [31:0]                 value_in;
	modport source (output valid, func, key_bytes, key_length, value_in, input ready);
	modport sink   (input valid, func, key_bytes, key_length, value_in, output ready);
endinterface

interface lpht_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [31:0] value_out;
	logic [4:0]  slot_index;
	logic [5:0]  entry_count;
	logic [3:0]  load_tenths;
	logic        over_threshold;
	modport source (output valid, status, value_out, slot_index, entry_count, load_tenths,
		over_threshold, input ready);
	modport sink   (input valid, status, value_out, slot_index, entry_count, load_tenths,
		over_threshold, output ready);
endinterface

// ----- src/linear_probe_hash_table_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_probe_hash_table_core: open-addressing hash table, linear probing
// Per request: hash the key, probe from the home slot for the key, then for an
// insert probe again from home for a free slot, compute the load and respond.
// One request at a time: a new one is taken once the result beat is accepted;
// the registered read port of the slot memory paces the probes.
// Reset empties every slot, clears the count and sets the threshold to 6.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_core #(
	parameter int TABLE_SLOTS = 32,
	parameter int KEY_BYTES   = 8,
	parameter int VALUE_BITS  = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [3:0] cfg_wdata,
	lpht_req_if.sink   req,
	lpht_rsp_if.source rsp
);
	import lpht_pkg::*;

	localparam int IDX_W  = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
	localparam int CNTW   = $clog2(TABLE_SLOTS + 1);
	localparam int PRB_W  = $clog2(TABLE_SLOTS + 1);
	localparam int LDW    = CNTW + 4;

	seq_state_t state_q, state_d;
	logic [THR_W-1:0] thr_q;
	logic [2:0]  func_q;
	logic [31:0] vin_q;
	logic [IDX_W-1:0] pos_q;
	logic [PRB_W-1:0] n_q;
	logic        phase_q;
	logic [CNTW-1:0] cnt_q;
	logic [1:0]  st_q;
	logic [31:0] vout_q;
	logic [IDX_W-1:0] slot_q;
	logic [LDW-1:0] ld_q;

	logic        h_done;
	logic [63:0] h_hash, h_key;
	logic [3:0]  h_len;
	logic [1:0]  r_status;
	logic [63:0] r_hash, r_key;
	logic [3:0]  r_len;
	logic [VALUE_BITS-1:0] r_value;
	logic        ws_en, we_en, wv_en;
	logic [1:0]  ws_val;
	logic [VALUE_BITS-1:0] wv_val;
	logic [IDX_W-1:0] w_idx;
	logic [IDX_W-1:0] home;
	logic        hit;
	logic [IDX_W-1:0] pos_nx;

	lpht_hash #(.KEY_BYTES(KEY_BYTES)) u_hash (
		.clk(clk), .arst_n(arst_n), .start(req.valid && req.ready),
		.key_bytes(req.key_bytes), .key_length(req.key_length),
		.done(h_done), .hash(h_hash), .key(h_key), .len(h_len)
	);

	lpht_store #(.TABLE_SLOTS(TABLE_SLOTS), .VALUE_BITS(VALUE_BITS), .IDX_W(IDX_W)) u_store (
		.clk(clk), .arst_n(arst_n), .rd_idx(pos_q),
		.rd_status(r_status), .rd_hash(r_hash), .rd_key(r_key), .rd_len(r_len),
		.rd_value(r_value),
		.wr_status_en(ws_en), .wr_status(ws_val), .wr_entry_en(we_en),
		.wr_value_en(wv_en), .wr_idx(w_idx), .wr_hash(h_hash), .wr_key(h_key),
		.wr_len(h_len), .wr_value(wv_val)
	);

	assign home   = IDX_W'(h_hash % 64'(TABLE_SLOTS));
	assign hit    = r_status == SL_USED && r_hash == h_hash && r_len == h_len && r_key == h_key;
	assign pos_nx = (pos_q == IDX_W'(TABLE_SLOTS - 1)) ? '0 : pos_q + 1'b1;
	assign wv_val = VALUE_BITS'(vin_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg_we && cfg_wdata >= THR_MIN && cfg_wdata <= THR_MAX) begin
			thr_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		rsp.valid = 1'b0;
		ws_en = 1'b0; we_en = 1'b0; wv_en = 1'b0;
		ws_val = SL_USED;
		w_idx = pos_q;
		case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) state_d = ST_HASH;
			end
			ST_HASH: if (h_done) state_d = ST_FIND;
			ST_FIND: begin
				if (phase_q) begin
					if (hit || r_status == SL_EMPTY || n_q == PRB_W'(TABLE_SLOTS - 1)) begin
						if (func_q == FN_INSERT && !hit) state_d = ST_FREE;
						else state_d = ST_LOAD;
						if (hit && func_q == FN_SET) begin
							wv_en = 1'b1; w_idx = pos_q;
						end
						if (hit && func_q == FN_DELETE) begin
							ws_en = 1'b1; ws_val = SL_TOMB; w_idx = pos_q;
						end
					end
				end
			end
			ST_FREE: begin
				if (phase_q) begin
					if (r_status != SL_USED) begin
						ws_en = 1'b1; we_en = 1'b1; wv_en = 1'b1; w_idx = pos_q;
						state_d = ST_LOAD;
					end else if (n_q == PRB_W'(TABLE_SLOTS - 1)) begin
						state_d = ST_LOAD;
					end
				end
			end
			ST_LOAD: state_d = ST_OUT;
			ST_OUT: begin
				rsp.valid = 1'b1;
				if (rsp.ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (state_q == ST_FREE && phase_q && r_status != SL_USED) begin
			cnt_q <= cnt_q + 1'b1;
		end else if (state_q == ST_FIND && phase_q && hit && func_q == FN_DELETE
			&& cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				func_q <= req.func;
				vin_q  <= req.value_in;
				st_q   <= RS_NOTFND;
				vout_q <= '0;
				slot_q <= '0;
			end
			ST_HASH: begin
				pos_q <= home; n_q <= '0; phase_q <= 1'b0;
			end
			ST_FIND, ST_FREE: begin
				phase_q <= ~phase_q;
				if (phase_q) begin
					if (state_d != state_q) begin
						pos_q <= home; n_q <= '0;
					end else begin
						pos_q <= pos_nx;
						n_q   <= n_q + 1'b1;
					end
					if (state_q == ST_FIND && hit && func_q <= FN_DELETE) begin
						slot_q <= pos_q;
						case (func_q)
							FN_INSERT: st_q <= RS_EXISTS;
							FN_GET, FN_SET, FN_DELETE: begin
								st_q <= RS_OK; vout_q <= 32'(r_value);
							end
							default: st_q <= RS_OK;
						endcase
					end
					if (state_q == ST_FREE && state_d != state_q) begin
						if (r_status != SL_USED) begin
							st_q <= RS_OK; slot_q <= pos_q;
						end else begin
							st_q <= RS_FULL;
						end
					end
				end
			end
			ST_LOAD: ld_q <= LDW'(cnt_q) * LDW'(10) / LDW'(TABLE_SLOTS);
			default: ;
		endcase
	end

	assign rsp.status         = st_q;
	assign rsp.value_out      = vout_q;
	assign rsp.slot_index     = SLOT_W'(slot_q);
	assign rsp.entry_count    = CNT_W'(cnt_q);
	assign rsp.load_tenths    = LOAD_W'(ld_q);
	assign rsp.over_threshold = LOAD_W'(ld_q) >= thr_q;
endmodule

// ----- src/lpht_hash.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_hash: byte-serial djb2-style hash with a zero seed
// One key byte per cycle: h = h*33 + byte, 64-bit wrap.
// ----------------------------------------------------------------------------
module lpht_hash #(
	parameter int KEY_BYTES = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [63:0]          key_bytes,
	input  logic [3:0]           key_length,
	output logic                 done,
	output logic [63:0]          hash,
	output logic [63:0]          key,
	output logic [3:0]           len
);
	import lpht_pkg::*;

	logic [63:0] hash_q, key_q, raw_q;
	logic [3:0]  len_q, idx_q;
	logic        busy_q;
	logic [3:0]  len_sat;
	logic [7:0]  b;

	assign len_sat = (key_length > 4'(KEY_BYTES)) ? 4'(KEY_BYTES) : key_length;
	assign b = raw_q[7:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (busy_q && idx_q == len_q) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			hash_q <= '0;
			key_q  <= '0;
			raw_q  <= key_bytes;
			len_q  <= len_sat;
			idx_q  <= '0;
		end else if (busy_q && idx_q != len_q) begin
			hash_q <= (hash_q << 5) + hash_q + 64'(b);
			key_q  <= key_q | (64'(b) << {idx_q[2:0], 3'b000});
			raw_q  <= raw_q >> 8;
			idx_q  <= idx_q + 4'd1;
		end
	end

	assign done = busy_q && idx_q == len_q;
	assign hash = hash_q;
	assign key  = key_q;
	assign len  = len_q;
endmodule

// ----- src/lpht_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_store: slot storage
// Status flip-flops cleared at reset; key, hash, length and value memories.
// ----------------------------------------------------------------------------
module lpht_store #(
	parameter int TABLE_SLOTS = 32,
	parameter int VALUE_BITS  = 32,
	parameter int IDX_W       = 5
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [IDX_W-1:0]      rd_idx,
	output logic [1:0]            rd_status,
	output logic [63:0]           rd_hash,
	output logic [63:0]           rd_key,
	output logic [3:0]            rd_len,
	output logic [VALUE_BITS-1:0] rd_value,
	input  logic                  wr_status_en,
	input  logic [1:0]            wr_status,
	input  logic                  wr_entry_en,
	input  logic                  wr_value_en,
	input  logic [IDX_W-1:0]      wr_idx,
	input  logic [63:0]           wr_hash,
	input  logic [63:0]           wr_key,
	input  logic [3:0]            wr_len,
	input  logic [VALUE_BITS-1:0] wr_value
);
	import lpht_pkg::*;

	logic [1:0]            status_q [TABLE_SLOTS];
	logic [63:0]           hash_mem [TABLE_SLOTS];
	logic [63:0]           key_mem  [TABLE_SLOTS];
	logic [3:0]            len_mem  [TABLE_SLOTS];
	logic [VALUE_BITS-1:0] val_mem  [TABLE_SLOTS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TABLE_SLOTS; i++) status_q[i] <= SL_EMPTY;
		end else if (wr_status_en) begin
			status_q[wr_idx] <= wr_status;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_entry_en) begin
			hash_mem[wr_idx] <= wr_hash;
			key_mem[wr_idx]  <= wr_key;
			len_mem[wr_idx]  <= wr_len;
		end
		if (wr_value_en) val_mem[wr_idx] <= wr_value;
		rd_status <= status_q[rd_idx];
		rd_hash   <= hash_mem[rd_idx];
		rd_key    <= key_mem[rd_idx];
		rd_len    <= len_mem[rd_idx];
		rd_value  <= val_mem[rd_idx];
	end
endmodule
